FILE: hw/rtl/cta_pkg.sv
`timescale 1ns / 1ps
// Package for the cascaded temperature average.
// Field widths, opcodes, averaging limits and parameter defaults; no dependencies.
package cta_pkg;

  localparam int OP_W   = 2;
  localparam int TEMP_W = 12;
  localparam int AVG_W  = 12;
  localparam int WIN_W  = 7;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(36);

  localparam int SHORT_DEPTH_DEF  = 60;
  localparam int LONG_DEPTH_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // magnitude of the most negative average
  localparam int AVG_MAG = 2 ** (AVG_W - 1);

  localparam logic signed [AVG_W-1:0] AVG_HI = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic signed [AVG_W-1:0] AVG_LO = {1'b1, {(AVG_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_MINUTE  = 2'd0,
    OP_HOUR    = 2'd1,
    OP_PRELOAD = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

endpackage

FILE: hw/rtl/cta_in_if.sv
`timescale 1ns / 1ps
// Input channel: valid/ready with opcode and temperature per beat.
// Depends on cta_pkg.
interface cta_in_if;
  import cta_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [TEMP_W-1:0] temperature;

  modport source (output valid, output opcode, output temperature, input ready);
  modport sink   (input valid, input opcode, input temperature, output ready);
endinterface

FILE: hw/rtl/cta_out_if.sv
`timescale 1ns / 1ps
// Output channel: valid/ready with both averages per beat.
// Depends on cta_pkg.
interface cta_out_if;
  import cta_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] short_average;
  logic signed [AVG_W-1:0] long_average;

  modport source (output valid, output short_average, output long_average, input ready);
  modport sink   (input valid, input short_average, input long_average, output ready);
endinterface

FILE: hw/rtl/cascaded_temperature_average.sv
`timescale 1ns / 1ps
// Cascaded temperature average: minute ring and hour ring in synchronous RAMs.
// Minute beats: read, update running sum, multiply by the reciprocal of the depth.
// Hour beats: read, update running sum, restoring divide by the window.
// Preload beats sweep both rings one entry a cycle; opcode 3 goes straight to the output state.
// One beat in flight, none taken until the last has left the output state; the next is taken while a result waits.
// After reset a clearing pass zeroes both rings; no beat is taken during it.
module cascaded_temperature_average #(
  parameter int SHORT_DEPTH  = cta_pkg::SHORT_DEPTH_DEF,
  parameter int LONG_DEPTH   = cta_pkg::LONG_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = cta_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      long_window_we_i,
  input  logic [cta_pkg::WIN_W-1:0] long_window_i,
  cta_in_if.sink                    in_i,
  cta_out_if.source                 out_o
);
  import cta_pkg::*;

  localparam int MAXD  = (SHORT_DEPTH > LONG_DEPTH) ? SHORT_DEPTH : LONG_DEPTH;
  localparam int SPW   = $clog2(SHORT_DEPTH);
  localparam int LPW   = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
  localparam int IW    = $clog2(MAXD);
  localparam int WW    = $clog2(LONG_DEPTH + 1);
  localparam int DW    = $clog2(MAXD + 1);
  localparam int SUM_W = TEMP_W + $clog2(MAXD) + 2;
  localparam int CW    = $clog2(SUM_W);

  localparam int          RCP_SH = SUM_W + $clog2(SHORT_DEPTH);
  localparam int          RCP_W  = SUM_W + 1;
  localparam logic [63:0] RCP    = ((64'd1 << RCP_SH) + 64'(SHORT_DEPTH) - 64'd1)
                                   / 64'(SHORT_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_UPD, S_MUL, S_DIV, S_FIN, S_FILL, S_OUT
  } state_e;

  state_e                    state_q;
  op_e                       op_q;
  logic signed [TEMP_W-1:0]  t_q;
  logic [WIN_W-1:0]          win_q;
  logic [SPW-1:0]            mp_q;
  logic [LPW-1:0]            hp_q;
  logic signed [SUM_W-1:0]   msum_q;
  logic signed [SUM_W-1:0]   hsum_q;
  logic signed [AVG_W-1:0]   hmean_q;
  logic signed [AVG_W-1:0]   wmean_q;
  logic [IW-1:0]             idx_q;
  logic [DW-1:0]             rem_q;
  logic [DW-1:0]             div_q;
  logic [SUM_W-1:0]          quo_q;
  logic                      neg_q;
  logic [CW-1:0]             cnt_q;
  logic                      out_valid_q;
  logic signed [AVG_W-1:0]   out_short_q;
  logic signed [AVG_W-1:0]   out_long_q;

  logic signed [SAMPLE_WIDTH-1:0] minute_mem [SHORT_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] hour_mem [LONG_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] m_rd_q;
  logic signed [SAMPLE_WIDTH-1:0] h_rd_q;

  logic                           m_we;
  logic [SPW-1:0]                 m_wa;
  logic signed [SAMPLE_WIDTH-1:0] m_wd;
  logic                           h_we;
  logic [LPW-1:0]                 h_wa;
  logic signed [SAMPLE_WIDTH-1:0] h_wd;

  logic [WW-1:0]           ew;
  op_e                     in_op;
  logic                    in_acc;
  logic signed [SUM_W-1:0] sum_m;
  logic signed [SUM_W-1:0] sum_h;
  logic signed [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0]        mag;
  logic [LPW:0]            hp_inc;
  logic [LPW-1:0]          hp_nx;
  logic [SPW-1:0]          mp_nx;
  logic [DW:0]             rem_sh;
  logic                    ge;
  logic [DW:0]             rem_sub;
  logic signed [AVG_W-1:0] res;
  logic signed [SUM_W-1:0] t_ext;
  logic signed [SUM_W-1:0] w_ext;
  logic [SUM_W+RCP_W-1:0]  prod;

  assign in_i.ready          = (state_q == S_IDLE);
  assign in_acc              = in_i.valid && in_i.ready;
  assign in_op               = op_e'(in_i.opcode);
  assign out_o.valid         = out_valid_q;
  assign out_o.short_average = out_short_q;
  assign out_o.long_average  = out_long_q;

  always_comb begin
    if (win_q == '0) begin
      ew = WW'(1);
    end else if (int'(win_q) > LONG_DEPTH) begin
      ew = WW'(LONG_DEPTH);
    end else begin
      ew = WW'(win_q);
    end
  end

  assign sum_m   = msum_q + SUM_W'(t_q) - SUM_W'(m_rd_q);
  assign sum_h   = hsum_q + SUM_W'(hmean_q) - SUM_W'(h_rd_q);
  assign sum_new = (op_q == OP_MINUTE) ? sum_m : sum_h;
  assign mag     = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

  assign mp_nx  = (int'(mp_q) == SHORT_DEPTH - 1) ? '0 : mp_q + SPW'(1);
  assign hp_inc = {1'b0, hp_q} + (LPW+1)'(1);
  assign hp_nx  = (int'(hp_inc) >= int'(ew)) ? '0 : hp_inc[LPW-1:0];

  assign t_ext = SUM_W'(in_i.temperature);
  assign w_ext = SUM_W'({1'b0, ew});

  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = ge ? rem_sh - {1'b0, div_q} : rem_sh;

  assign prod = {{RCP_W{1'b0}}, quo_q} * {{SUM_W{1'b0}}, RCP_W'(RCP)};

  always_comb begin
    if (!neg_q && quo_q > SUM_W'(AVG_MAG - 1)) begin
      res = AVG_HI;
    end else if (neg_q && quo_q > SUM_W'(AVG_MAG)) begin
      res = AVG_LO;
    end else if (neg_q) begin
      res = AVG_W'(-quo_q);
    end else begin
      res = AVG_W'(quo_q);
    end
  end

  always_comb begin
    m_we = 1'b0;
    m_wa = mp_q;
    m_wd = SAMPLE_WIDTH'(t_q);
    h_we = 1'b0;
    h_wa = hp_q;
    h_wd = SAMPLE_WIDTH'(hmean_q);
    case (state_q)
      S_UPD: begin
        m_we = (op_q == OP_MINUTE);
        h_we = (op_q == OP_HOUR);
      end
      S_FILL, S_CLEAR: begin
        m_wa = idx_q[SPW-1:0];
        h_wa = idx_q[LPW-1:0];
        m_we = int'(idx_q) < SHORT_DEPTH;
        if (state_q == S_CLEAR) begin
          m_wd = '0;
          h_wd = '0;
          h_we = int'(idx_q) < LONG_DEPTH;
        end else begin
          h_wd = SAMPLE_WIDTH'(t_q);
          h_we = int'(idx_q) < int'(ew);
        end
      end
      default: begin
        m_we = 1'b0;
        h_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      minute_mem[m_wa] <= m_wd;
    end
    m_rd_q <= minute_mem[mp_q];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hour_mem[h_wa] <= h_wd;
    end
    h_rd_q <= hour_mem[hp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      op_q        <= OP_NONE;
      t_q         <= '0;
      win_q       <= WIN_RESET;
      mp_q        <= '0;
      hp_q        <= '0;
      msum_q      <= '0;
      hsum_q      <= '0;
      hmean_q     <= '0;
      wmean_q     <= '0;
      idx_q       <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      quo_q       <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_short_q <= '0;
      out_long_q  <= '0;
    end else begin
      if (long_window_we_i) begin
        win_q <= long_window_i;
      end
      if (out_valid_q && out_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (int'(idx_q) == MAXD - 1) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_q  <= in_op;
            t_q   <= in_i.temperature;
            idx_q <= '0;
            case (in_op)
              OP_MINUTE, OP_HOUR: state_q <= S_UPD;
              OP_PRELOAD: begin
                msum_q  <= t_ext * SUM_W'(SHORT_DEPTH);
                hsum_q  <= t_ext * w_ext;
                state_q <= S_FILL;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_UPD: begin
          if (op_q == OP_MINUTE) begin
            msum_q  <= sum_m;
            mp_q    <= mp_nx;
            state_q <= S_MUL;
          end else begin
            hsum_q  <= sum_h;
            hp_q    <= hp_nx;
            div_q   <= DW'(ew);
            state_q <= S_DIV;
          end
          quo_q <= mag;
          neg_q <= sum_new[SUM_W-1];
          rem_q <= '0;
          cnt_q <= '0;
        end
        S_MUL: begin
          quo_q   <= SUM_W'(prod >> RCP_SH);
          state_q <= S_FIN;
        end
        S_DIV: begin
          rem_q <= rem_sub[DW-1:0];
          quo_q <= {quo_q[SUM_W-2:0], ge};
          cnt_q <= cnt_q + CW'(1);
          if (int'(cnt_q) == SUM_W - 1) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (op_q == OP_MINUTE) begin
            hmean_q <= res;
          end else begin
            wmean_q <= res;
          end
          state_q <= S_OUT;
        end
        S_FILL: begin
          idx_q <= idx_q + IW'(1);
          if (int'(idx_q) == MAXD - 1) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_short_q <= hmean_q;
            out_long_q  <= wmean_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(mp_q) < SHORT_DEPTH) && (int'(hp_q) < LONG_DEPTH))
    else $error("ring position beyond ring depth");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_short_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && op_q == OP_MINUTE) |->
      (quo_q <= (neg_q ? SUM_W'(AVG_MAG) : SUM_W'(AVG_MAG - 1))))
    else $error("minute average out of range, running sum corrupted");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result beat raised outside the output state");

endmodule
